FILE: rtl/lms_pkg.sv
package lms_pkg;
  localparam int MAX_TAPS_DEF = 1024;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W = 24;
  localparam int STEP_W = 16;
  localparam int TAPS_W = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS_IN_USE = 1'd1;
  localparam logic [TAPS_W-1:0] TAPS_RESET = 11'd128;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_EST,
    ST_UPD,
    ST_OUT
  } lms_state_t;
endpackage

FILE: rtl/lms_adaptive_fir.sv
// LMS adaptive FIR filter. Each accepted transaction (reference and desired
// sample) produces one estimate/error transaction. Coefficients and the
// sample delay line live in two single-port-write, registered-read memories;
// the delay line is a circular buffer sized to the next power of two.
// The filter pass does one multiply-accumulate per cycle. The coefficient
// update pass works in two steps a tap: read, then multiply and write back.
// The input is stalled from an accepted item until its result has been
// taken at the output. After reset a clearing pass zeroes the first
// MAX_TAPS entries of both memories before the first item is accepted.
module lms_adaptive_fir #(
  parameter int MAX_TAPS = lms_pkg::MAX_TAPS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [lms_pkg::SAMPLE_W-1:0] in_reference_sample,
  input  logic signed [lms_pkg::SAMPLE_W-1:0] in_desired_sample,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [lms_pkg::SAMPLE_W-1:0] out_estimate,
  output logic signed [lms_pkg::SAMPLE_W-1:0] out_error_out,
  input  logic cfg_we,
  input  logic [lms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lms_pkg::STEP_W-1:0] cfg_data
);
  import lms_pkg::*;
  localparam int AW = $clog2(MAX_TAPS);
  localparam int CW = AW + 1;

  lms_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [TAPS_W-1:0] taps_r;
  logic [AW-1:0] head_r;
  logic [CW-1:0] k_r, kd_r, ntaps;
  logic phase_r;
  logic signed [63:0] acc_r;
  logic signed [SAMPLE_W-1:0] des_r, est_r, err_r;
  logic signed [47:0] prod;
  logic signed [SAMPLE_W+STEP_W:0] ems_r;
  logic [AW-1:0] c_raddr, h_raddr, c_waddr, h_waddr;
  logic c_we, h_we;
  logic [COEF_W-1:0] c_wdata, c_rdata;
  logic [SAMPLE_W-1:0] h_wdata, h_rdata;
  logic rd_ok_r;

  always_comb begin
    if (taps_r == '0) ntaps = CW'(1);
    else if (32'(taps_r) > MAX_TAPS) ntaps = CW'(MAX_TAPS);
    else ntaps = CW'(taps_r);
  end

  lms_mem #(.DEPTH(MAX_TAPS), .W(COEF_W), .AW(AW)) u_coef (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata));
  lms_mem #(.DEPTH(1 << AW), .W(SAMPLE_W), .AW(AW)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata));

  // sample k steps old is at head+k (head decremented on each new sample)
  assign c_raddr = k_r[AW-1:0];
  assign h_raddr = AW'(head_r + k_r[AW-1:0]);

  logic signed [COEF_W+SAMPLE_W-1:0] mac_p;
  assign mac_p = $signed(c_rdata) * $signed(h_rdata);

  logic signed [64:0] est_full;
  logic signed [SAMPLE_W:0] err_full;
  logic signed [SAMPLE_W-1:0] est_sat;
  always_comb begin
    est_full = (65'(acc_r) + 65'sd2097152) >>> 22;
    if (est_full > 65'sd32767) est_sat = 16'sh7fff;
    else if (est_full < -65'sd32768) est_sat = 16'sh8000;
    else est_sat = est_full[SAMPLE_W-1:0];
    err_full = 17'(des_r) - 17'(est_sat);
  end

  // product: sample times (err*mu)
  assign prod = 48'($signed(h_rdata)) * 48'(ems_r);

  logic signed [48:0] dl;
  logic signed [COEF_W+1:0] csum;
  always_comb begin
    dl = (49'(prod) + 49'sd4194304) >>> 23;
    csum = 26'($signed(c_rdata)) + 26'(dl[25:0]);
    if (dl > 49'sd16777215 || csum > 26'sd8388607) c_wdata = 24'h7fffff;
    else if (dl < -49'sd16777216 || csum < -26'sd8388608) c_wdata = 24'h800000;
    else c_wdata = csum[COEF_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (k_r == CW'(MAX_TAPS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_MAC;
      ST_MAC:   if (rd_ok_r && kd_r == ntaps - CW'(1)) state_nxt = ST_EST;
      ST_EST:   state_nxt = ST_UPD;
      ST_UPD:   if (phase_r && kd_r == ntaps - CW'(1)) state_nxt = ST_OUT;
      ST_OUT:   if (!out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
    c_we = 1'b0;
    h_we = 1'b0;
    c_waddr = kd_r[AW-1:0];
    h_waddr = AW'(head_r - AW'(1));
    h_wdata = in_reference_sample;
    unique case (state_r)
      ST_CLEAR: begin
        c_we = 1'b1;
        h_we = 1'b1;
        c_waddr = k_r[AW-1:0];
        h_waddr = k_r[AW-1:0];
        h_wdata = '0;
      end
      ST_IDLE: h_we = in_valid;
      ST_UPD:  c_we = phase_r;
      default: ;
    endcase
  end
  assign out_estimate = est_r;
  assign out_error_out = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      step_r <= '0;
      taps_r <= TAPS_RESET;
      head_r <= '0;
      k_r <= '0;
      kd_r <= '0;
      phase_r <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == REG_STEP_SIZE) step_r <= cfg_data;
        else if (cfg_index == REG_TAPS_IN_USE) taps_r <= cfg_data[TAPS_W-1:0];
      end
      rd_ok_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: k_r <= k_r + CW'(1);
        ST_IDLE: begin
          k_r <= '0;
          if (in_valid) begin
            head_r <= AW'(head_r - AW'(1));
            des_r <= in_desired_sample;
            acc_r <= '0;
          end
        end
        ST_MAC: begin
          if (k_r < ntaps) begin
            rd_ok_r <= 1'b1;
            kd_r <= k_r;
            k_r <= k_r + CW'(1);
          end
          if (rd_ok_r) acc_r <= acc_r + 64'(mac_p);
        end
        ST_EST: begin
          est_r <= est_sat;
          if (err_full > 17'sd32767) err_r <= 16'sh7fff;
          else if (err_full < -17'sd32768) err_r <= 16'sh8000;
          else err_r <= err_full[SAMPLE_W-1:0];
          k_r <= '0;
          phase_r <= 1'b0;
        end
        ST_UPD: begin
          // phase 0: issue read; phase 1: multiply done, write back
          if (!phase_r) begin
            ems_r <= $signed(err_r) * $signed({1'b0, step_r});
            kd_r <= k_r;
            phase_r <= 1'b1;
          end else begin
            k_r <= k_r + CW'(1);
            phase_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: rtl/lms_mem.sv
module lms_mem #(
  parameter int DEPTH = 1024,
  parameter int W = 16,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lms_pkg::*;

  localparam int DEPTH = MAX_TAPS_DEF;
  localparam int SETTLE = 2 * DEPTH + 100;
  localparam longint LIMIT = 4000000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] reference;
    logic signed [SAMPLE_W-1:0] desired;
  } sample_pair_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] estimate;
    logic signed [SAMPLE_W-1:0] error_out;
  } filter_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] in_reference_sample = '0;
  logic signed [SAMPLE_W-1:0] in_desired_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_estimate;
  logic signed [SAMPLE_W-1:0] out_error_out;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STEP_W-1:0] cfg_data = '0;

  lms_adaptive_fir dut (.*);

  always #1 clk = ~clk;

  sample_pair_t pending_pairs[$];
  filter_out_t expected_outputs[$];
  logic signed [COEF_W-1:0] coef_model[DEPTH];
  logic signed [SAMPLE_W-1:0] delay_model[DEPTH];
  int unsigned mu_model = 0;
  int unsigned taps_model = TAPS_RESET;
  int errors = 0;
  int pairs_sent = 0;
  int outputs_checked = 0;
  int phases_run = 0;
  longint cycles = 0;
  int send_gap = 0;
  int stall_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic filter_out_t lms_filter_step(sample_pair_t p);
    int unsigned n;
    longint acc, prod, delta, c, est, err;
    filter_out_t r;
    n = taps_model < 1 ? 1 : (taps_model > DEPTH ? DEPTH : taps_model);
    for (int k = DEPTH - 1; k > 0; k--) delay_model[k] = delay_model[k-1];
    delay_model[0] = p.reference;
    acc = 0;
    for (int k = 0; k < n; k++) acc += longint'(coef_model[k]) * longint'(delay_model[k]);
    est = (acc + (longint'(1) << 21)) >>> 22;
    if (est > 32767) est = 32767;
    if (est < -32768) est = -32768;
    err = longint'(p.desired) - est;
    if (err > 32767) err = 32767;
    if (err < -32768) err = -32768;
    for (int k = 0; k < n; k++) begin
      prod = longint'(delay_model[k]) * err * longint'(mu_model);
      delta = (prod + (longint'(1) << 22)) >>> 23;
      c = longint'(coef_model[k]) + delta;
      if (c > 8388607) c = 8388607;
      if (c < -8388608) c = -8388608;
      coef_model[k] = c[COEF_W-1:0];
    end
    r.estimate = est[SAMPLE_W-1:0];
    r.error_out = err[SAMPLE_W-1:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    logic next_valid;
    sample_pair_t p;
    cycles <= cycles + 1;
    if (rst_n) begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        p.reference = in_reference_sample;
        p.desired = in_desired_sample;
        expected_outputs.push_back(lms_filter_step(p));
        pairs_sent++;
        next_valid = 1'b0;
        send_gap = pick_gap();
      end
      if (!next_valid) begin
        if (send_gap > 0) send_gap--;
        else if (pending_pairs.size() > 0) begin
          p = pending_pairs.pop_front();
          in_reference_sample <= p.reference;
          in_desired_sample <= p.desired;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // monitor
  always @(posedge clk) begin
    filter_out_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_outputs.size() == 0) begin
          $error("unexpected transaction: estimate %0d error_out %0d",
                 out_estimate, out_error_out);
          errors++;
        end else begin
          e = expected_outputs.pop_front();
          outputs_checked++;
          if (out_estimate !== e.estimate) begin
            $error("estimate: expected %0d actual %0d", e.estimate, out_estimate);
            errors++;
          end
          if (out_error_out !== e.error_out) begin
            $error("error_out: expected %0d actual %0d", e.error_out, out_error_out);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 2047) - 1024);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[STEP_W-1:0];
    if (idx == REG_STEP_SIZE) mu_model = val & 16'hffff;
    else taps_model = val & 11'h7ff;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_pair(logic signed [SAMPLE_W-1:0] r, logic signed [SAMPLE_W-1:0] d);
    sample_pair_t p;
    p.reference = r;
    p.desired = d;
    pending_pairs.push_back(p);
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid || expected_outputs.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    phases_run++;
  endtask

  task automatic run_phase(int unsigned mu, int unsigned taps, int count);
    write_reg(REG_STEP_SIZE, mu);
    write_reg(REG_TAPS_IN_USE, taps);
    for (int i = 0; i < count; i++) queue_pair(rand_sample(), rand_sample());
    drain();
  endtask

  initial begin
    int unsigned mu, taps;
    for (int k = 0; k < DEPTH; k++) begin
      coef_model[k] = '0;
      delay_model[k] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // reset settings: frozen coefficients, default tap count
    queue_pair(16'sh7fff, 16'sh7fff);
    queue_pair(16'sh8000, 16'sh8000);
    queue_pair(16'sh7fff, 16'sh8000);
    queue_pair(16'sh0000, 16'sh0001);
    drain();
    // full step, drive coefficients into saturation
    write_reg(REG_STEP_SIZE, 16'hffff);
    write_reg(REG_TAPS_IN_USE, 4);
    repeat (4) queue_pair(16'sh7fff, 16'sh8000);
    repeat (3) queue_pair(16'sh8000, 16'sh8000);
    repeat (3) queue_pair(16'sh7fff, 16'sh7fff);
    drain();
    // zero taps acts as one
    write_reg(REG_TAPS_IN_USE, 0);
    queue_pair(16'sh4000, 16'sh7fff);
    queue_pair(16'sh8000, 16'sh0000);
    queue_pair(16'shffff, 16'sh8000);
    drain();
    // oversized tap count clamps to full depth
    write_reg(REG_STEP_SIZE, 1000);
    write_reg(REG_TAPS_IN_USE, 11'h7ff);
    queue_pair(16'sh7fff, 16'sh1234);
    queue_pair(16'sh8000, 16'shedcb);
    drain();
    run_phase(0, DEPTH, 3);
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 3))
        0: mu = 0;
        1: mu = 16'hffff;
        default: mu = $urandom_range(0, 65535);
      endcase
      taps = ($urandom_range(0, 5) == 0) ? $urandom_range(DEPTH - 8, 2047)
                                          : $urandom_range(1, 40);
      run_phase(mu, taps, taps > 64 ? 4 : 24);
    end
    $display("%0d transactions sent and %0d results checked over %0d configuration phases",
             pairs_sent, outputs_checked, phases_run);
    $display("step sizes from zero to full scale, tap counts from zero to above full depth");
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
